### design/rrw_pkg.sv
// ----------------------------------------------------------------------------
// rrw_pkg: shared definitions for the reorder receive window
// Field widths, the default window size and the result kind codes.
// ----------------------------------------------------------------------------
`default_nettype none

package rrw_pkg;

  localparam int SEQ_W  = 32;  // sequence number width
  localparam int BYTE_W = 8;   // data byte width

  localparam int WINDOW_DEFAULT = 32;

  // Result kind codes.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_ACK  = 1'b1;

endpackage

`default_nettype wire

### design/rrw_slot_store.sv
// ----------------------------------------------------------------------------
// rrw_slot_store: slot memory of the reorder receive window
// One data byte per slot in a synchronous memory with a registered read,
// plus one valid flag per slot in flip-flops that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module rrw_slot_store #(
  parameter int WINDOW = rrw_pkg::WINDOW_DEFAULT,
  parameter int AW     = (WINDOW > 1) ? $clog2(WINDOW) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [AW-1:0]             wr_addr,
  input  wire logic [rrw_pkg::BYTE_W-1:0] wr_data,
  input  wire logic                      clr_en,
  input  wire logic [AW-1:0]             rd_addr,
  output logic      [rrw_pkg::BYTE_W-1:0] rd_data,
  output logic                           rd_valid
);

  logic [rrw_pkg::BYTE_W-1:0] mem [WINDOW];
  logic [WINDOW-1:0]          valid_r;
  logic [rrw_pkg::BYTE_W-1:0] rd_data_r;

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Valid flags. A write sets its slot; a delivery clears the read slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (clr_en) begin
        valid_r[rd_addr] <= 1'b0;
      end
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = valid_r[rd_addr];

endmodule

`default_nettype wire

### design/reorder_receive_window.sv
// Timing: a packet is accepted in S_IDLE, then each delivered byte passes
//   through S_CHECK and S_EMIT, and a final S_CHECK issues the acknowledgement.
// Throughput: one packet at a time; the next packet is accepted as soon as the
//   acknowledgement sits in the output register. Output back-pressure holds
//   the ack in S_CHECK and a byte in S_EMIT. Each byte needs both states because the slot memory's read is registered.
// Reset (rst_n, synchronous, active low): all slots invalid, next expected 0.
// ----------------------------------------------------------------------------
// reorder_receive_window: receive side of a selective-repeat window
// Stores out-of-order bytes in a slot memory and releases them in order,
// closing every packet with a cumulative acknowledgement.
// ----------------------------------------------------------------------------
`default_nettype none

module reorder_receive_window #(
  parameter int WINDOW = rrw_pkg::WINDOW_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // Packet input
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [rrw_pkg::BYTE_W-1:0] in_payload,
  input  wire logic [rrw_pkg::SEQ_W-1:0]  in_seq_no,
  // Result output
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_kind,
  output logic      [rrw_pkg::BYTE_W-1:0] out_byte_out,
  output logic      [rrw_pkg::SEQ_W-1:0]  out_number,
  output logic                            out_last
);

  localparam int SW = rrw_pkg::SEQ_W;
  localparam int BW = rrw_pkg::BYTE_W;
  localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [SW-1:0] WIN_SEQ   = SW'(WINDOW);
  localparam logic [AW:0]   WIN_SUM   = (AW+1)'(WINDOW);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW - 1);

  // The sequencer walks the window from the head slot. CHECK looks at the
  // head's valid flag while the memory reads its byte; EMIT hands that byte
  // to the output register and advances the head.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT
  } state_t;

  state_t          state_r, state_nxt;
  logic [SW-1:0]   next_exp_r, next_exp_nxt;  // next expected sequence number
  logic [AW-1:0]   head_r, head_nxt;          // next_exp_r modulo WINDOW

  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r, out_kind_nxt;
  logic [BW-1:0]   out_byte_r, out_byte_nxt;
  logic [SW-1:0]   out_num_r, out_num_nxt;
  logic            out_last_r, out_last_nxt;

  logic            out_free;
  logic            in_accept;
  logic [SW-1:0]   offset;
  logic            in_window;
  logic [AW:0]     slot_sum;
  logic [AW-1:0]   wr_slot;
  logic            wr_en;
  logic            clr_en;
  logic [BW-1:0]   rd_data;
  logic            rd_valid;

  // The output register can take a new result when it is empty or being
  // drained in this cycle.
  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign in_accept = in_valid && in_ready;

  // Window test without wrap: seq_no >= next expected and the distance from
  // it stays below WINDOW. The slot follows from the head plus that distance,
  // which stays below twice WINDOW, so one conditional subtract suffices.
  assign offset    = in_seq_no - next_exp_r;
  assign in_window = (in_seq_no >= next_exp_r) && (offset < WIN_SEQ);
  assign slot_sum  = {1'b0, head_r} + {1'b0, offset[AW-1:0]};
  assign wr_slot   = (slot_sum >= WIN_SUM) ? AW'(slot_sum - WIN_SUM) : slot_sum[AW-1:0];
  assign wr_en     = in_accept && in_window;

  // A slot is released when its byte moves into the output register.
  assign clr_en    = (state_r == S_EMIT) && out_free;

  rrw_slot_store #(
    .WINDOW (WINDOW),
    .AW     (AW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_slot),
    .wr_data  (in_payload),
    .clr_en   (clr_en),
    .rd_addr  (head_r),
    .rd_data  (rd_data),
    .rd_valid (rd_valid)
  );

  always_comb begin
    state_nxt     = state_r;
    next_exp_nxt  = next_exp_r;
    head_nxt      = head_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_num_nxt   = out_num_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (rd_valid) begin
          // The memory read of the head slot completes at this edge.
          state_nxt = S_EMIT;
        end else if (out_free) begin
          // No more bytes in order: close the packet with the ack.
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rrw_pkg::KIND_ACK;
          out_byte_nxt  = '0;
          out_num_nxt   = next_exp_r;
          out_last_nxt  = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = rrw_pkg::KIND_BYTE;
          out_byte_nxt  = rd_data;
          out_num_nxt   = next_exp_r;
          out_last_nxt  = 1'b0;
          next_exp_nxt  = next_exp_r + 1'b1;
          // When the counter wraps to zero the slot index restarts at zero,
          // since zero modulo any window is zero.
          if (head_r == LAST_SLOT || next_exp_r == '1) begin
            head_nxt = '0;
          end else begin
            head_nxt = head_r + 1'b1;
          end
          state_nxt = S_CHECK;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      next_exp_r  <= '0;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      next_exp_r  <= next_exp_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_num_r  <= out_num_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_byte_out = out_byte_r;
  assign out_number   = out_num_r;
  assign out_last     = out_last_r;

endmodule

`default_nettype wire

### test/reorder_receive_window_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reorder_receive_window_tb: self-checking bench for the reorder receive window
// Sends windows of packets in shuffled or reversed order, with stale, far,
// duplicate and stray packets mixed in. A predictor replays each accepted
// packet and queues the bytes and the acknowledgement that it must release.
// The result stream is checked field by field. Both sides idle at random.
// ----------------------------------------------------------------------------

module reorder_receive_window_tb;

  localparam int BYTE_W        = rrw_pkg::BYTE_W;
  localparam int SEQ_W         = rrw_pkg::SEQ_W;
  localparam int WIN           = rrw_pkg::WINDOW_DEFAULT;
  localparam int RANDOM_ITEMS  = 310;
  // A packet that fills the last gap releases a whole window, each byte passing
  // through S_CHECK and S_EMIT, so allow for that before the block is taken to be idle.
  localparam int SETTLE_CYCLES = 2 * WIN + 16;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 400000;

  typedef struct {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [SEQ_W-1:0]  number;
    logic              last;
  } rx_result_t;

  // Receive window predictor: keeps its own slot store and next expected
  // number, and the queue of results still owed by the block.
  class reorder_predictor;
    logic [BYTE_W-1:0] slot_byte [WIN];
    bit                slot_full [WIN];
    logic [SEQ_W-1:0]  next_seq;
    rx_result_t        due_results [$];
    int                mismatches;

    function new();
      next_seq   = '0;
      mismatches = 0;
      foreach (slot_full[i]) slot_full[i] = 1'b0;
    endfunction

    function void accept_packet(logic [BYTE_W-1:0] data, logic [SEQ_W-1:0] seq);
      logic [SEQ_W:0] bound;
      int             s;
      rx_result_t     r;
      // The upper edge of the window does not wrap.
      bound = {1'b0, next_seq} + (SEQ_W + 1)'(WIN);
      if ({1'b0, seq} < bound && seq >= next_seq) begin
        s = int'(seq % SEQ_W'(WIN));
        slot_byte[s] = data;
        slot_full[s] = 1'b1;
      end
      for (int i = 0; i < WIN; i++) begin
        s = int'(next_seq % SEQ_W'(WIN));
        if (!slot_full[s]) break;
        r.kind   = rrw_pkg::KIND_BYTE;
        r.data   = slot_byte[s];
        r.number = next_seq;
        r.last   = 1'b0;
        due_results.push_back(r);
        slot_full[s] = 1'b0;
        next_seq     = next_seq + 1'b1;
      end
      r.kind   = rrw_pkg::KIND_ACK;
      r.data   = '0;
      r.number = next_seq;
      r.last   = 1'b1;
      due_results.push_back(r);
    endfunction

    task report(string what);
      $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(rx_result_t got);
      rx_result_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result kind=%0d byte=%h number=%0d last=%0d",
                         got.kind, got.data, got.number, got.last));
        return;
      end
      want = due_results.pop_front();
      if (got.kind !== want.kind)
        report($sformatf("kind %0d, want %0d (number %0d)", got.kind, want.kind,
                         want.number));
      if (got.data !== want.data)
        report($sformatf("byte %h, want %h (number %0d)", got.data, want.data,
                         want.number));
      if (got.number !== want.number)
        report($sformatf("number %0d, want %0d", got.number, want.number));
      if (got.last !== want.last)
        report($sformatf("last %0d, want %0d (number %0d)", got.last, want.last,
                         want.number));
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [BYTE_W-1:0] in_payload = '0;
  logic [SEQ_W-1:0]  in_seq_no  = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic              out_kind;
  logic [BYTE_W-1:0] out_byte_out;
  logic [SEQ_W-1:0]  out_number;
  logic              out_last;

  logic long_hold_req = 1'b0;
  int   cycle_count   = 0;
  int   burst_left    = 0;

  reorder_predictor rx_window = new();

  always #2 clk = ~clk;

  reorder_receive_window #(
    .WINDOW(WIN)
  ) i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_payload  (in_payload),
    .in_seq_no   (in_seq_no),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_kind    (out_kind),
    .out_byte_out(out_byte_out),
    .out_number  (out_number),
    .out_last    (out_last)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Every result taken by the receiver is checked against the oldest one owed.
  always @(posedge clk) begin
    rx_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.kind   = out_kind;
      got.data   = out_byte_out;
      got.number = out_number;
      got.last   = out_last;
      rx_window.check_result(got);
    end
  end

  // Offers one packet and waits for it to be taken. Packets go out in bursts;
  // at the end of a burst valid drops for a short random gap.
  task automatic send_packet(input logic [BYTE_W-1:0] data, input logic [SEQ_W-1:0] seq);
    in_valid   <= 1'b1;
    in_payload <= data;
    in_seq_no  <= seq;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rx_window.accept_packet(data, seq);
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 30);
    end
  endtask

  // Stops offering and waits until every owed result has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (rx_window.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A packet off the regular sequence: stale, just past the window, anywhere
  // in the number range, a repeat, or a stray one inside the window.
  task automatic send_noise(input logic [SEQ_W-1:0] repeat_seq);
    logic [SEQ_W-1:0] head;
    logic [SEQ_W-1:0] seq;
    head = rx_window.next_seq;
    case ($urandom_range(0, 4))
      0:       seq = (head > 40) ? head - $urandom_range(1, 40) : $urandom;
      1:       seq = head + WIN + $urandom_range(0, 8);
      2:       seq = $urandom;
      3:       seq = repeat_seq;
      default: seq = head + $urandom_range(0, WIN - 1);
    endcase
    send_packet(BYTE_W'($urandom_range(0, 255)), seq);
  endtask

  // Receiver: stalls in segments of random length, each with its own stall
  // rate, and once holds off for a long stretch so the block backs up.
  initial begin
    int stall_pct;
    bit long_hold_done;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 20;
        3:       stall_pct = 50;
        default: stall_pct = 80;
      endcase
      repeat ($urandom_range(40, 200)) begin
        if (long_hold_req && !long_hold_done) begin
          long_hold_done = 1'b1;
          out_ready     <= 1'b0;
          repeat (LONG_HOLD) @(posedge clk);
        end
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
        @(posedge clk);
      end
    end
  end

  // Sender. The wrap of the next expected number past the top of the range
  // needs four billion deliveries and is out of reach of any run.
  initial begin
    logic [SEQ_W-1:0] order [WIN];
    logic [SEQ_W-1:0] base;
    logic [SEQ_W-1:0] swap;
    int               size;
    int               j;
    int               items;
    bit               full_fill;
    bit               mid_pause_done;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: in order, a gap and its fill, stale, just outside and
    // on the last slot of the window, a duplicate overwrite, far numbers.
    send_packet(8'hFF, 32'd0);
    send_packet(8'h00, 32'd2);
    send_packet(8'hA5, 32'd1);
    send_packet(8'h5A, 32'd1);
    send_packet(8'h12, 32'd35);
    send_packet(8'h34, 32'd34);
    send_packet(8'hCD, 32'd34);
    send_packet(8'h77, 32'hFFFF_FFFF);
    send_packet(8'h01, 32'h8000_0000);
    send_packet(8'h80, 32'h7FFF_FFFF);
    send_packet(8'h3C, 32'd3);
    wait_drained();

    // Random part: windows of consecutive numbers in scrambled order. The
    // first one is a full window sent backwards, so its last packet releases
    // every slot at once, and it goes out while the receiver holds off.
    long_hold_req  <= 1'b1;
    items          = 0;
    mid_pause_done = 1'b0;
    while (items < RANDOM_ITEMS) begin
      base      = rx_window.next_seq;
      full_fill = (items == 0);
      if (full_fill) size = WIN;
      else if ($urandom_range(0, 3) == 0) size = $urandom_range(9, WIN);
      else size = $urandom_range(1, 8);
      for (int k = 0; k < size; k++) order[k] = base + k;
      if (full_fill || $urandom_range(0, 4) == 0) begin
        for (int k = 0; k < size / 2; k++) begin
          swap                = order[k];
          order[k]            = order[size - 1 - k];
          order[size - 1 - k] = swap;
        end
      end else begin
        for (int k = size - 1; k > 0; k--) begin
          j        = $urandom_range(0, k);
          swap     = order[k];
          order[k] = order[j];
          order[j] = swap;
        end
      end
      for (int k = 0; k < size; k++) begin
        if (!full_fill && $urandom_range(0, 99) < 15) begin
          send_noise(order[$urandom_range(0, size - 1)]);
          items++;
        end
        send_packet(BYTE_W'($urandom_range(0, 255)), order[k]);
        items++;
      end
      if (!mid_pause_done && items >= RANDOM_ITEMS / 2) begin
        wait_drained();
        mid_pause_done = 1'b1;
      end
    end

    wait_drained();
    if (rx_window.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
design/rrw_pkg.sv
design/rrw_slot_store.sv
design/reorder_receive_window.sv
test/reorder_receive_window_tb.sv
